// ----- hdl/sorted_timer_queue_core_macros.svh -----
// ----------------------------------------------------------------------------
// Sorted timer queue: assertion macros
// Concurrent assertion wrappers shared by the queue RTL. Define NO_ASSERTIONS
// to compile them away.
// ----------------------------------------------------------------------------
`ifndef SORTED_TIMER_QUEUE_CORE_MACROS_SVH
`define SORTED_TIMER_QUEUE_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
// property holds at every clock edge out of reset
`define STQ_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// same-cycle implication
`define STQ_ASSERT_SAME(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define STQ_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define STQ_ASSERT(name, clk, rst_n, prop, msg)
`define STQ_ASSERT_SAME(name, clk, rst_n, ante, cons, msg)
`define STQ_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- hdl/stq_pkg.sv -----
// ----------------------------------------------------------------------------
// Sorted timer queue package
// Field widths, command and status codes, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package stq_pkg;

    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int DEF_ID_BITS     = 8;

    localparam int DL_W      = 64;
    localparam int DELAY_W   = 32;
    localparam int ID_PORT_W = 8;
    localparam int MAX_ID_W  = 16;
    localparam int MODE_W    = 2;
    localparam int STATUS_W  = 2;

    localparam logic [MODE_W-1:0] MODE_SET   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TICK  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
    localparam logic [STATUS_W-1:0] ST_CLEAR_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_SET_FULL    = 2'd2;

    typedef enum logic [3:0] {
        CS_IDLE,
        CS_DISPATCH,
        CS_SET_WALK,
        CS_SET_PLACE,
        CS_CLEAR_WALK,
        CS_TICK_HEAD,
        CS_TICK_CHECK,
        CS_TICK_SHIFT,
        CS_RESPOND
    } ctl_state_t;

    typedef enum logic [1:0] {
        WA_ZERO,
        WA_PLUS1,
        WA_MINUS1,
        WA_FILL
    } wr_addr_sel_t;

    typedef struct packed {
        logic         load;
        logic         ptr_init;
        logic         ptr_down;
        logic         rd_en;
        logic         wr_en;
        logic         wr_new;
        wr_addr_sel_t wa_sel;
        logic         fill_inc;
        logic         cnt_inc;
        logic         cnt_dec;
        logic         cnt_load;
        logic         res_full;
        logic         res_empty;
        logic         res_expire;
    } dp_cmd_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              cnt_zero;
        logic              cnt_full;
        logic              rd_more;
        logic              pend_valid;
        logic              pend_zero;
        logic              data_later;
        logic              data_expired;
        logic              data_match;
    } dp_stat_t;

endpackage

// ----- hdl/sorted_timer_queue_core.sv -----
// ----------------------------------------------------------------------------
// Sorted timer queue core
// Deadline-ordered timer queue: set, clear and tick commands.
// ----------------------------------------------------------------------------
// A command on an empty queue, a set on a full queue or a mode-3 command goes
// from dispatch straight to the response; a tick that does not expire reads
// only the head; a set walks up to count entries, a clear and an expiring tick
// walk all of them, with one RAM read and at most one write per entry.
// Throughput: next command accepted the cycle after done; results cannot be
// stalled. Reset (rst_n low, async) empties the queue; RAM is not cleared.
module sorted_timer_queue_core import stq_pkg::*; #(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int ID_BITS     = DEF_ID_BITS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [MODE_W-1:0]    mode,
    input  logic [ID_PORT_W-1:0] timer_id,
    input  logic [DELAY_W-1:0]   delay_usec,
    input  logic [DL_W-1:0]      now_usec,
    output logic                 done,
    output logic                 expired_valid,
    output logic [ID_PORT_W-1:0] expired_id,
    output logic [STATUS_W-1:0]  status
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    stq_controller u_ctl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd),
        .stat  (stat)
    );

    stq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_BITS     (ID_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .mode          (mode),
        .timer_id      (timer_id),
        .delay_usec    (delay_usec),
        .now_usec      (now_usec),
        .expired_valid (expired_valid),
        .expired_id    (expired_id),
        .status        (status)
    );

endmodule

// ----- hdl/stq_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data (old data on a
// same-address read and write).
// ----------------------------------------------------------------------------
module stq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hdl/stq_datapath.sv -----
// ----------------------------------------------------------------------------
// Sorted timer queue datapath
// Entry RAM, command registers, walk pointers, entry count and result
// registers. Acts on commands from the controller, reports compare status.
// ----------------------------------------------------------------------------
`include "sorted_timer_queue_core_macros.svh"

module stq_datapath import stq_pkg::*; #(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int ID_BITS     = DEF_ID_BITS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  dp_cmd_t              cmd,
    output dp_stat_t             stat,
    input  logic [MODE_W-1:0]    mode,
    input  logic [ID_PORT_W-1:0] timer_id,
    input  logic [DELAY_W-1:0]   delay_usec,
    input  logic [DL_W-1:0]      now_usec,
    output logic                 expired_valid,
    output logic [ID_PORT_W-1:0] expired_id,
    output logic [STATUS_W-1:0]  status
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int ENT_W = DL_W + ID_BITS;

    logic [MODE_W-1:0]    mode_reg;
    logic [ID_BITS-1:0]   id_reg;
    logic [DL_W-1:0]      key_reg;      // deadline for set, now for tick
    logic [CNT_W-1:0]     count_reg;
    logic [IDX_W-1:0]     rd_idx_reg;
    logic [CNT_W-1:0]     rd_left_reg;
    logic                 pend_valid_reg;
    logic [IDX_W-1:0]     pend_idx_reg;
    logic [CNT_W-1:0]     fill_reg;
    logic                 exp_valid_reg;
    logic [ID_PORT_W-1:0] exp_id_reg;
    logic [STATUS_W-1:0]  status_reg;

    logic [DL_W:0]        dl_sum;
    logic [DL_W-1:0]      key_next;
    logic [MAX_ID_W-1:0]  id_in_wide;
    logic [MAX_ID_W-1:0]  id_out_wide;
    logic [CNT_W-1:0]     cnt_m1;

    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [ENT_W-1:0]     ram_wdata;
    logic [ENT_W-1:0]     ram_rdata;
    logic [DL_W-1:0]      rd_dl;
    logic [ID_BITS-1:0]   rd_id;

    // saturating deadline
    assign dl_sum     = (DL_W+1)'(now_usec) + (DL_W+1)'(delay_usec);
    assign key_next   = (mode != MODE_SET) ? now_usec :
                        (dl_sum[DL_W] ? {DL_W{1'b1}} : dl_sum[DL_W-1:0]);
    assign id_in_wide = MAX_ID_W'(timer_id);
    assign cnt_m1     = count_reg - CNT_W'(1);

    assign rd_dl       = ram_rdata[ENT_W-1:ID_BITS];
    assign rd_id       = ram_rdata[ID_BITS-1:0];
    assign id_out_wide = MAX_ID_W'(rd_id);

    always_comb
    begin
        case (cmd.wa_sel)
            WA_ZERO:   ram_waddr = '0;
            WA_PLUS1:  ram_waddr = pend_idx_reg + IDX_W'(1);
            WA_MINUS1: ram_waddr = pend_idx_reg - IDX_W'(1);
            WA_FILL:   ram_waddr = fill_reg[IDX_W-1:0];
            default:   ram_waddr = '0;
        endcase
    end

    assign ram_we    = cmd.wr_en;
    assign ram_wdata = cmd.wr_new ? {key_reg, id_reg} : ram_rdata;

    stq_ram #(
        .WIDTH (ENT_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_idx_reg),
        .rdata (ram_rdata)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            rd_left_reg    <= '0;
            pend_valid_reg <= 1'b0;
            fill_reg       <= '0;
        end
        else
        begin
            pend_valid_reg <= cmd.rd_en;
            if (cmd.ptr_init)
            begin
                rd_left_reg <= count_reg;
            end
            else if (cmd.rd_en)
            begin
                rd_left_reg <= rd_left_reg - CNT_W'(1);
            end
            if (cmd.ptr_init)
            begin
                fill_reg <= '0;
            end
            else if (cmd.fill_inc)
            begin
                fill_reg <= fill_reg + CNT_W'(1);
            end
            if (cmd.cnt_inc)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (cmd.cnt_dec)
            begin
                count_reg <= cnt_m1;
            end
            else if (cmd.cnt_load)
            begin
                count_reg <= fill_reg;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        pend_idx_reg <= rd_idx_reg;
        if (cmd.load)
        begin
            mode_reg <= mode;
            id_reg   <= id_in_wide[ID_BITS-1:0];
            key_reg  <= key_next;
        end
        if (cmd.ptr_init)
        begin
            rd_idx_reg <= cmd.ptr_down ? cnt_m1[IDX_W-1:0] : '0;
        end
        else if (cmd.rd_en)
        begin
            rd_idx_reg <= cmd.ptr_down ? rd_idx_reg - IDX_W'(1) : rd_idx_reg + IDX_W'(1);
        end
        if (cmd.load)
        begin
            status_reg    <= ST_OK;
            exp_valid_reg <= 1'b0;
            exp_id_reg    <= '0;
        end
        else if (cmd.res_full)
        begin
            status_reg <= ST_SET_FULL;
        end
        else if (cmd.res_empty)
        begin
            status_reg <= ST_CLEAR_EMPTY;
        end
        else if (cmd.res_expire)
        begin
            exp_valid_reg <= 1'b1;
            exp_id_reg    <= id_out_wide[ID_PORT_W-1:0];
        end
    end

    assign stat.mode         = mode_reg;
    assign stat.cnt_zero     = (count_reg == '0);
    assign stat.cnt_full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign stat.rd_more      = (rd_left_reg != '0);
    assign stat.pend_valid   = pend_valid_reg;
    assign stat.pend_zero    = (pend_idx_reg == '0);
    assign stat.data_later   = (rd_dl > key_reg);
    assign stat.data_expired = (key_reg > rd_dl);
    assign stat.data_match   = (rd_id == id_reg);

    assign expired_valid = exp_valid_reg;
    assign expired_id    = exp_id_reg;
    assign status        = status_reg;

    `STQ_ASSERT(a_count_bound, clk, rst_n, count_reg <= CNT_W'(QUEUE_DEPTH), "entry count over depth")
    `STQ_ASSERT_SAME(a_wr_in_range, clk, rst_n, cmd.wr_en, CNT_W'(ram_waddr) <= count_reg, "write beyond queue tail")
    `STQ_ASSERT(a_walk_bound, clk, rst_n, rd_left_reg <= count_reg, "walk runs past the entry count")

endmodule

// ----- hdl/stq_controller.sv -----
// ----------------------------------------------------------------------------
// Sorted timer queue controller
// Command handshake and the state machine that sequences set, clear and
// tick walks over the entry RAM.
// ----------------------------------------------------------------------------
`include "sorted_timer_queue_core_macros.svh"

module stq_controller import stq_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    output logic     done,
    output dp_cmd_t  cmd,
    input  dp_stat_t stat
);

    ctl_state_t state_reg;
    ctl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CS_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            CS_IDLE:
            begin
                if (start)
                begin
                    state_next = CS_DISPATCH;
                end
            end
            CS_DISPATCH:
            begin
                state_next = CS_RESPOND;
                case (stat.mode)
                    MODE_SET:
                    begin
                        if (!stat.cnt_full && !stat.cnt_zero)
                        begin
                            state_next = CS_SET_WALK;
                        end
                    end
                    MODE_CLEAR:
                    begin
                        if (!stat.cnt_zero)
                        begin
                            state_next = CS_CLEAR_WALK;
                        end
                    end
                    MODE_TICK:
                    begin
                        if (!stat.cnt_zero)
                        begin
                            state_next = CS_TICK_HEAD;
                        end
                    end
                    default:
                    begin
                        state_next = CS_RESPOND;
                    end
                endcase
            end
            CS_SET_WALK:
            begin
                if (stat.pend_valid)
                begin
                    if (!stat.data_later)
                    begin
                        state_next = CS_RESPOND;
                    end
                    else if (stat.pend_zero)
                    begin
                        state_next = CS_SET_PLACE;
                    end
                end
            end
            CS_SET_PLACE:
            begin
                state_next = CS_RESPOND;
            end
            CS_CLEAR_WALK:
            begin
                if (!stat.rd_more && !stat.pend_valid)
                begin
                    state_next = CS_RESPOND;
                end
            end
            CS_TICK_HEAD:
            begin
                state_next = CS_TICK_CHECK;
            end
            CS_TICK_CHECK:
            begin
                state_next = stat.data_expired ? CS_TICK_SHIFT : CS_RESPOND;
            end
            CS_TICK_SHIFT:
            begin
                if (!stat.rd_more && !stat.pend_valid)
                begin
                    state_next = CS_RESPOND;
                end
            end
            CS_RESPOND:
            begin
                state_next = CS_IDLE;
            end
            default:
            begin
                state_next = CS_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd  = '0;
        busy = (state_reg != CS_IDLE);
        done = (state_reg == CS_RESPOND);
        case (state_reg)
            CS_IDLE:
            begin
                cmd.load = start;
            end
            CS_DISPATCH:
            begin
                case (stat.mode)
                    MODE_SET:
                    begin
                        cmd.ptr_down = 1'b1;
                        if (stat.cnt_full)
                        begin
                            cmd.res_full = 1'b1;
                        end
                        else if (stat.cnt_zero)
                        begin
                            cmd.wr_en   = 1'b1;
                            cmd.wr_new  = 1'b1;
                            cmd.wa_sel  = WA_ZERO;
                            cmd.cnt_inc = 1'b1;
                        end
                        else
                        begin
                            cmd.ptr_init = 1'b1;
                        end
                    end
                    MODE_CLEAR:
                    begin
                        if (stat.cnt_zero)
                        begin
                            cmd.res_empty = 1'b1;
                        end
                        else
                        begin
                            cmd.ptr_init = 1'b1;
                        end
                    end
                    MODE_TICK:
                    begin
                        cmd.ptr_init = !stat.cnt_zero;
                    end
                    default:
                    begin
                        cmd.ptr_init = 1'b0;
                    end
                endcase
            end
            CS_SET_WALK:
            begin
                // walk down from the tail, shifting later deadlines up by one
                cmd.ptr_down = 1'b1;
                cmd.rd_en    = stat.rd_more;
                if (stat.pend_valid)
                begin
                    cmd.wr_en  = 1'b1;
                    cmd.wa_sel = WA_PLUS1;
                    if (!stat.data_later)
                    begin
                        cmd.wr_new  = 1'b1;
                        cmd.cnt_inc = 1'b1;
                    end
                end
            end
            CS_SET_PLACE:
            begin
                cmd.wr_en   = 1'b1;
                cmd.wr_new  = 1'b1;
                cmd.wa_sel  = WA_ZERO;
                cmd.cnt_inc = 1'b1;
            end
            CS_CLEAR_WALK:
            begin
                // compact survivors toward the head
                cmd.rd_en = stat.rd_more;
                if (stat.pend_valid && !stat.data_match)
                begin
                    cmd.wr_en    = 1'b1;
                    cmd.wa_sel   = WA_FILL;
                    cmd.fill_inc = 1'b1;
                end
                cmd.cnt_load = !stat.rd_more && !stat.pend_valid;
            end
            CS_TICK_HEAD:
            begin
                cmd.rd_en = 1'b1;
            end
            CS_TICK_CHECK:
            begin
                if (stat.data_expired)
                begin
                    cmd.res_expire = 1'b1;
                    cmd.cnt_dec    = 1'b1;
                    cmd.rd_en      = stat.rd_more;
                end
            end
            CS_TICK_SHIFT:
            begin
                cmd.rd_en = stat.rd_more;
                if (stat.pend_valid)
                begin
                    cmd.wr_en  = 1'b1;
                    cmd.wa_sel = WA_MINUS1;
                end
            end
            CS_RESPOND:
            begin
                cmd.load = 1'b0;
            end
            default:
            begin
                cmd.load = 1'b0;
            end
        endcase
    end

    `STQ_ASSERT_NEXT(a_accept_dispatch, clk, rst_n, start && !busy, state_reg == CS_DISPATCH, "transfer not dispatched")
    `STQ_ASSERT_NEXT(a_done_to_idle, clk, rst_n, done, !busy, "not idle after result")
    `STQ_ASSERT_SAME(a_shift_has_data, clk, rst_n, cmd.wr_en && !cmd.wr_new, stat.pend_valid, "entry move without read data")

endmodule
